// ===== rtl/sas_pkg.sv =====
// Shared types, constants and helpers for the spectral angle similarity block.
`default_nettype none

package sas_pkg;

    localparam int DEF_N_BANDS     = 256;
    localparam int DEF_SAMPLE_BITS = 12;

    localparam int ACC_W       = 32;
    localparam int Q_FRAC_BITS = 16;
    localparam int SIM_W       = Q_FRAC_BITS + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [SIM_W-1:0] Q_ONE   = SIM_W'(1) << Q_FRAC_BITS;

    localparam logic OP_TARGET = 1'b0;
    localparam logic OP_PIXEL  = 1'b1;

    // finished pixel sums handed from the front end to the divider
    typedef struct packed {
        logic [ACC_W-1:0] cross_sum;
        logic [ACC_W-1:0] target_energy;
        logic [ACC_W-1:0] pixel_energy;
    } t_acc_set;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_NUM,
        BK_MUL_DEN,
        BK_CMP,
        BK_DIV,
        BK_DONE
    } t_back_state;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [ACC_W-1:0] term);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + {1'b0, term};
        return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sas_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sas_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/sas_front.sv =====
// Front end: band counter, target store and the three saturating accumulators.
`default_nettype none

module sas_front import sas_pkg::*; #(
    parameter int N_BANDS     = DEF_N_BANDS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_op,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_last,
    input  wire logic [Q_CNT_W-1:0]     i_q_count,
    output logic                        o_q_push,
    output t_acc_set                    o_q_data
);

    localparam int IDX_W  = $clog2(N_BANDS + 1);
    localparam int ADDR_W = $clog2(N_BANDS);
    localparam int SQ_W   = 2 * SAMPLE_BITS;

    logic [IDX_W-1:0]       r_band_idx;
    logic [IDX_W-1:0]       n_band_idx;
    logic                   in_range;
    logic                   accept;
    logic [SAMPLE_BITS-1:0] rd_target;

    logic                   r_s1_valid;
    logic                   r_s1_op;
    logic                   r_s1_last;
    logic                   r_s1_first;
    logic                   r_s1_in_range;
    logic [SAMPLE_BITS-1:0] r_s1_smp;
    logic [SQ_W-1:0]        r_s1_sq;

    logic [ACC_W-1:0]       r_ss, r_sx, r_xx;
    logic [ACC_W-1:0]       n_ss, n_sx, n_xx;
    logic [SQ_W-1:0]        prod;
    logic                   push_pending;

    assign in_range = r_band_idx < IDX_W'(N_BANDS);
    assign accept   = i_in_valid && o_in_ready;

    // a last pixel in stage 1 will push next edge; keep a slot for it
    assign push_pending = r_s1_valid && (r_s1_op == OP_PIXEL) && r_s1_last;
    assign o_in_ready   = ({1'b0, i_q_count} + (Q_CNT_W + 1)'(push_pending))
                          < (Q_CNT_W + 1)'(QUEUE_DEPTH);

    always_comb begin
        n_band_idx = r_band_idx;
        if (i_last) begin
            n_band_idx = '0;
        end else if (in_range) begin
            n_band_idx = r_band_idx + IDX_W'(1);
        end
    end

    sas_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (N_BANDS)
    ) u_target_store (
        .i_clk   (i_clk),
        .i_we    (accept && (i_op == OP_TARGET) && in_range),
        .i_waddr (r_band_idx[ADDR_W-1:0]),
        .i_wdata (i_sample),
        .i_raddr (r_band_idx[ADDR_W-1:0]),
        .o_rdata (rd_target)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_idx <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_band_idx <= n_band_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op       <= i_op;
            r_s1_last     <= i_last;
            r_s1_first    <= (r_band_idx == '0);
            r_s1_in_range <= in_range;
            r_s1_smp      <= i_sample;
            r_s1_sq       <= SQ_W'(i_sample) * SQ_W'(i_sample);
        end
    end

    assign prod = SQ_W'(r_s1_smp) * SQ_W'(rd_target);

    always_comb begin
        n_ss = r_ss;
        n_sx = r_sx;
        n_xx = r_xx;
        if (r_s1_op == OP_TARGET) begin
            if (r_s1_first) begin
                n_ss = '0;
            end
            if (r_s1_in_range) begin
                n_ss = sat_add(n_ss, ACC_W'(r_s1_sq));
            end
        end else begin
            if (r_s1_first) begin
                n_sx = '0;
                n_xx = '0;
            end
            if (r_s1_in_range) begin
                n_sx = sat_add(n_sx, ACC_W'(prod));
                n_xx = sat_add(n_xx, ACC_W'(r_s1_sq));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ss <= '0;
            r_sx <= '0;
            r_xx <= '0;
        end else if (r_s1_valid) begin
            r_ss <= n_ss;
            r_sx <= n_sx;
            r_xx <= n_xx;
        end
    end

    assign o_q_push                = push_pending;
    assign o_q_data.cross_sum      = n_sx;
    assign o_q_data.target_energy  = n_ss;
    assign o_q_data.pixel_energy   = n_xx;

endmodule

`default_nettype wire

// ===== rtl/sas_queue.sv =====
// Short request queue between the accumulating front end and the divider.
`default_nettype none

module sas_queue import sas_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire t_acc_set       i_data,
    input  wire logic           i_pop,
    output logic                o_valid,
    output t_acc_set            o_data,
    output logic [Q_CNT_W-1:0]  o_count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_acc_set           r_data [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_data[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sas_back.sv =====
// Back end: products, restoring division to Q0.16 and the result register.
`default_nettype none

module sas_back import sas_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire t_acc_set         i_q_data,
    output logic                  o_q_pop,
    input  wire logic [SIM_W-1:0] i_threshold,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [SIM_W-1:0]      o_similarity,
    output logic                  o_detected,
    output logic                  o_zero_energy
);

    localparam int PROD_W = 2 * ACC_W;
    localparam int STEP_W = $clog2(Q_FRAC_BITS);

    t_back_state         r_state, n_state;
    logic [ACC_W-1:0]    r_sx, r_ss, r_xx;
    logic                r_zero;
    logic [PROD_W-1:0]   r_num, r_den, r_rem;
    logic [SIM_W-1:0]    r_quot;
    logic [STEP_W-1:0]   r_step;

    logic [ACC_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [PROD_W:0]     shifted, diff;
    logic                step_ge;
    logic                num_ge;
    logic                out_free;
    logic                load_out;

    // one shared multiplier: sx*sx first, then ss*xx
    assign mul_a = (r_state == BK_MUL_NUM) ? r_sx : r_ss;
    assign mul_b = (r_state == BK_MUL_NUM) ? r_sx : r_xx;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign num_ge  = r_num >= r_den;
    assign shifted = {r_rem, 1'b0};
    assign diff    = shifted - {1'b0, r_den};
    assign step_ge = shifted >= {1'b0, r_den};

    assign out_free = !o_out_valid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = BK_MUL_NUM;
                end
            end
            BK_MUL_NUM: n_state = BK_MUL_DEN;
            BK_MUL_DEN: n_state = BK_CMP;
            BK_CMP: begin
                n_state = (r_zero || num_ge) ? BK_DONE : BK_DIV;
            end
            BK_DIV: begin
                if (r_step == STEP_W'(Q_FRAC_BITS - 1)) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    r_sx   <= i_q_data.cross_sum;
                    r_ss   <= i_q_data.target_energy;
                    r_xx   <= i_q_data.pixel_energy;
                    r_zero <= (i_q_data.target_energy == '0) ||
                              (i_q_data.pixel_energy == '0);
                end
            end
            BK_MUL_NUM: r_num <= mul_p;
            BK_MUL_DEN: r_den <= mul_p;
            BK_CMP: begin
                r_rem  <= r_num;
                r_step <= '0;
                if (r_zero) begin
                    r_quot <= '0;
                end else if (num_ge) begin
                    r_quot <= Q_ONE;
                end else begin
                    r_quot <= '0;
                end
            end
            BK_DIV: begin
                r_rem  <= step_ge ? diff[PROD_W-1:0] : shifted[PROD_W-1:0];
                r_quot <= {r_quot[SIM_W-2:0], step_ge};
                r_step <= r_step + STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_similarity  <= r_quot;
            o_detected    <= r_quot > i_threshold;
            o_zero_energy <= r_zero;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spectral_angle_similarity_top.sv =====
// Top level of the streaming squared spectral cosine detector.
//
// Input channel (i_in_valid / o_in_ready) carries one band sample per
// request: i_op selects target load or pixel, i_last ends the vector.
// Target requests fill the target store and its energy; pixel requests
// accumulate the cross sum and pixel energy. Each pixel request with
// i_last set yields one result on the output channel (o_out_valid /
// i_out_ready): Q1.16 squared cosine, detection flag, zero-energy flag.
// Samples are taken at one per cycle while o_in_ready is high; stage 1
// registers wait on the registered target store read for the accumulators.
// After a queue pop the divider does two multiplies on one shared 32x32
// multiplier, a compare and 16 restoring steps, skipped when the ratio
// reaches one or an energy is zero. A two-entry queue lets a pixel's
// division overlap the next pixel's bands; with short pixels the divider
// sets the result rate and o_in_ready drops when the queue fills. A stalled
// receiver holds the result register, the divider then waits, and the queue
// backs up to the input. Reset clears the band counter, accumulators,
// queue and threshold; the target store is not cleared and must be loaded
// before pixels are sent. The user writes the threshold through
// i_cfg_wr_en / i_cfg_wr_data while idle; the block does not enforce it.
`default_nettype none

module spectral_angle_similarity_top import sas_pkg::*; #(
    parameter int N_BANDS     = DEF_N_BANDS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [SIM_W-1:0]       i_cfg_wr_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_op,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_last,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [SIM_W-1:0]            o_similarity,
    output logic                        o_detected,
    output logic                        o_zero_energy
);

    logic [SIM_W-1:0]   r_threshold;
    logic               q_push, q_pop, q_valid;
    t_acc_set           q_in, q_out;
    logic [Q_CNT_W-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    sas_front #(
        .N_BANDS     (N_BANDS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_sample   (i_sample),
        .i_last     (i_last),
        .i_q_count  (q_count),
        .o_q_push   (q_push),
        .o_q_data   (q_in)
    );

    sas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out),
        .o_count (q_count)
    );

    sas_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_out),
        .o_q_pop       (q_pop),
        .i_threshold   (r_threshold),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_similarity  (o_similarity),
        .o_detected    (o_detected),
        .o_zero_energy (o_zero_energy)
    );

    // the front end must never push into a full queue
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_count < Q_CNT_W'(QUEUE_DEPTH)))
        else $error("request pushed into full queue");

    a_sim_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_similarity <= Q_ONE))
        else $error("similarity above one");

    a_zero_forces_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_energy) |-> (o_similarity == '0 && !o_detected))
        else $error("zero energy result not cleared");

    a_detect_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_detected) |-> (o_similarity > r_threshold))
        else $error("detection flag without exceeding threshold");

endmodule

`default_nettype wire

// ===== bench/spectral_angle_similarity_top_tb.sv =====
// Self-checking testbench for the streaming squared spectral cosine detector.
`timescale 1ns / 100ps

module spectral_angle_similarity_top_tb import sas_pkg::*; ();

    localparam int N_BANDS      = DEF_N_BANDS;
    localparam int SAMPLE_BITS  = DEF_SAMPLE_BITS;
    localparam int RESET_CYCLES = 12;
    localparam int CFG_SETTLE   = 32;
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 250;
    localparam int CHUNK_ITEMS  = 20;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [SIM_W-1:0] similarity;
        logic             detected;
        logic             zero_energy;
    } t_cosine_result;

    typedef enum {FILL_RANDOM, FILL_COPY, FILL_ZERO, FILL_MAX} t_fill_kind;

    class t_cosine_scoreboard;
        logic [SAMPLE_BITS-1:0] tgt_band [N_BANDS];
        logic [ACC_W-1:0]       tgt_energy;
        logic [ACC_W-1:0]       cross_acc;
        logic [ACC_W-1:0]       pix_energy;
        int unsigned            band_pos;
        logic [SIM_W-1:0]       threshold;
        logic [SIM_W-1:0]       last_sim;
        t_cosine_result         expected_cosines [$];
        int                     errors;
        int                     requests_seen;
        int                     results_checked;
        int                     saturations;

        function new();
            tgt_energy      = '0;
            cross_acc       = '0;
            pix_energy      = '0;
            band_pos        = 0;
            threshold       = '0;
            last_sim        = '0;
            errors          = 0;
            requests_seen   = 0;
            results_checked = 0;
            saturations     = 0;
        endfunction

        function void set_threshold(logic [SIM_W-1:0] v);
            threshold = v;
        endfunction

        function int pending();
            return expected_cosines.size();
        endfunction

        function logic [ACC_W-1:0] acc_add(logic [ACC_W-1:0] a, logic [ACC_W-1:0] t);
            logic [ACC_W:0] s;
            s = {1'b0, a} + {1'b0, t};
            if (s[ACC_W]) begin
                saturations++;
                return ACC_MAX;
            end
            return s[ACC_W-1:0];
        endfunction

        // floor(65536 * sx^2 / (ss*xx)), clamped to one
        function logic [SIM_W-1:0] cosine_q16(logic [ACC_W-1:0] sx, logic [ACC_W-1:0] ss,
                                              logic [ACC_W-1:0] xx);
            logic [63:0]  num;
            logic [63:0]  den;
            logic [127:0] quot;
            num = 64'(sx) * 64'(sx);
            den = 64'(ss) * 64'(xx);
            if (num >= den) return Q_ONE;
            quot = ({64'b0, num} << Q_FRAC_BITS) / {64'b0, den};
            return quot[SIM_W-1:0];
        endfunction

        function void note_request(logic op, logic [SAMPLE_BITS-1:0] smp, logic last);
            logic [ACC_W-1:0] sq;
            t_cosine_result   r;
            requests_seen++;
            sq = ACC_W'(smp) * ACC_W'(smp);
            if (band_pos == 0) begin
                if (op == OP_TARGET) begin
                    tgt_energy = '0;
                end else begin
                    cross_acc  = '0;
                    pix_energy = '0;
                end
            end
            // past the last band the sample is dropped, the position sticks
            if (band_pos < N_BANDS) begin
                if (op == OP_TARGET) begin
                    tgt_band[band_pos] = smp;
                    tgt_energy = acc_add(tgt_energy, sq);
                end else begin
                    cross_acc  = acc_add(cross_acc, ACC_W'(smp) * ACC_W'(tgt_band[band_pos]));
                    pix_energy = acc_add(pix_energy, sq);
                end
                band_pos++;
            end
            if (last) begin
                band_pos = 0;
                if (op == OP_PIXEL) begin
                    if (tgt_energy == '0 || pix_energy == '0) begin
                        r.similarity  = '0;
                        r.detected    = 1'b0;
                        r.zero_energy = 1'b1;
                    end else begin
                        r.similarity  = cosine_q16(cross_acc, tgt_energy, pix_energy);
                        r.detected    = r.similarity > threshold;
                        r.zero_energy = 1'b0;
                        last_sim      = r.similarity;
                    end
                    expected_cosines.push_back(r);
                end
            end
        endfunction

        function void check_result(logic [SIM_W-1:0] sim, logic det, logic ze);
            t_cosine_result want;
            if (expected_cosines.size() == 0) begin
                $error("result with no pixel pending: similarity %0d", sim);
                errors++;
                return;
            end
            want = expected_cosines.pop_front();
            results_checked++;
            if (sim !== want.similarity) begin
                $error("similarity: expected %0d, got %0d", want.similarity, sim);
                errors++;
            end
            if (det !== want.detected) begin
                $error("detected: expected %0d, got %0d", want.detected, det);
                errors++;
            end
            if (ze !== want.zero_energy) begin
                $error("zero_energy: expected %0d, got %0d", want.zero_energy, ze);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_wr_en;
    logic [SIM_W-1:0]       cfg_wr_data;
    logic                   in_valid;
    logic                   o_in_ready;
    logic                   op_bit;
    logic [SAMPLE_BITS-1:0] sample_val;
    logic                   last_bit;
    logic                   o_out_valid;
    logic                   out_ready;
    logic [SIM_W-1:0]       o_similarity;
    logic                   o_detected;
    logic                   o_zero_energy;

    t_cosine_scoreboard     sb;
    int unsigned            cycle_count = 0;
    bit                     gaps_on = 1'b0;
    bit                     hold_req = 1'b0;
    int                     thr_writes = 0;

    // what the sender has issued so far, so that no unwritten band is read
    int unsigned            gen_band = 0;
    bit                     gen_written [N_BANDS];
    logic [SAMPLE_BITS-1:0] gen_store [N_BANDS];

    spectral_angle_similarity_top #(
        .N_BANDS     (N_BANDS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (op_bit),
        .i_sample      (sample_val),
        .i_last        (last_bit),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_similarity  (o_similarity),
        .o_detected    (o_detected),
        .o_zero_energy (o_zero_energy)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && o_in_ready) begin
            sb.note_request(op_bit, sample_val, last_bit);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            sb.check_result(o_similarity, o_detected, o_zero_energy);
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("spectral_angle_similarity_top test failed");
        $finish;
    end

    function automatic logic [SAMPLE_BITS-1:0] samp_pick();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_BITS'($urandom_range(1, 15));
            3:       return SAMPLE_BITS'($urandom_range(2048, 4095));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_req(input logic op, input logic [SAMPLE_BITS-1:0] smp,
                            input logic last);
        logic op_eff;
        op_eff = op;
        if (op_eff == OP_PIXEL && gen_band < N_BANDS && !gen_written[gen_band]) begin
            op_eff = OP_TARGET;
        end
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        op_bit     <= op_eff;
        sample_val <= smp;
        last_bit   <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (gen_band < N_BANDS) begin
            if (op_eff == OP_TARGET) begin
                gen_written[gen_band] = 1'b1;
                gen_store[gen_band]   = smp;
            end
            gen_band++;
        end
        if (last) gen_band = 0;
    endtask

    task automatic send_vector(input logic op, input int len, input t_fill_kind fill);
        logic [SAMPLE_BITS-1:0] smp;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_COPY: smp = (i < N_BANDS && gen_written[i]) ? gen_store[i] : samp_pick();
                FILL_ZERO: smp = '0;
                FILL_MAX:  smp = '1;
                default:   smp = samp_pick();
            endcase
            send_req(op, smp, i == len - 1);
        end
    endtask

    // stop offering, let every pending pixel come out, then let the block settle
    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [SIM_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        sb.set_threshold(v);
        thr_writes++;
    endtask

    initial begin
        int               sent;
        int               kind;
        int               len;
        logic [SIM_W-1:0] thr;

        sb = new();
        i_rst_n     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        op_bit      <= OP_TARGET;
        sample_val  <= '0;
        last_bit    <= 1'b0;
        out_ready   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_threshold('0);
        gaps_on = 1'b1;

        // short target, then equal, zero, orthogonal and single-band pixels
        send_req(OP_TARGET, '1, 1'b0);
        send_req(OP_TARGET, '0, 1'b0);
        send_req(OP_TARGET, 12'd1, 1'b0);
        send_req(OP_TARGET, 12'd2048, 1'b1);
        send_req(OP_PIXEL, '1, 1'b0);
        send_req(OP_PIXEL, '0, 1'b0);
        send_req(OP_PIXEL, 12'd1, 1'b0);
        send_req(OP_PIXEL, 12'd2048, 1'b1);
        send_vector(OP_PIXEL, 4, FILL_ZERO);
        send_req(OP_PIXEL, '0, 1'b0);
        send_req(OP_PIXEL, '1, 1'b1);
        send_req(OP_PIXEL, '1, 1'b1);
        // target with no energy
        send_req(OP_TARGET, '0, 1'b1);
        send_req(OP_PIXEL, '1, 1'b1);
        // op switched mid-vector: the sums of the other kind carry over
        send_req(OP_TARGET, '1, 1'b0);
        send_req(OP_PIXEL, 12'd7, 1'b0);
        send_req(OP_PIXEL, '1, 1'b1);
        send_req(OP_PIXEL, 12'd2048, 1'b0);
        send_req(OP_TARGET, 12'd100, 1'b1);
        send_req(OP_PIXEL, 12'd1, 1'b1);

        settle_idle();
        write_threshold(Q_ONE);
        // samples past the last band must leave the store alone
        send_vector(OP_TARGET, N_BANDS + 2, FILL_RANDOM);
        send_vector(OP_PIXEL, N_BANDS + 3, FILL_MAX);
        // pixel sums continue from the full pixel above and saturate
        send_req(OP_TARGET, '1, 1'b0);
        send_vector(OP_PIXEL, 3, FILL_MAX);
        send_vector(OP_PIXEL, 8, FILL_COPY);

        for (int chunk = 0; chunk < 4; chunk++) begin
            settle_idle();
            case (chunk)
                0:       thr = SIM_W'($urandom_range(0, Q_ONE));
                1:       thr = 17'hFFFF;
                2:       thr = sb.last_sim;
                default: thr = SIM_W'($urandom_range(30000, 65000));
            endcase
            write_threshold(thr);
            sent = 0;
            if (chunk == 1) begin
                // receiver holds off while single-band pixels keep coming
                hold_req = 1'b1;
                for (int k = 0; k < 12; k++) send_req(OP_PIXEL, samp_pick(), 1'b1);
                sent = 12;
            end
            if (chunk == 3) gaps_on = 1'b0;
            while (sent < CHUNK_ITEMS) begin
                kind = $urandom_range(0, 19);
                if (kind <= 8) begin
                    len = $urandom_range(1, 8);
                    send_vector(OP_PIXEL, len, FILL_RANDOM);
                end else if (kind <= 10) begin
                    len = $urandom_range(9, 48);
                    send_vector(OP_PIXEL, len, FILL_RANDOM);
                end else if (kind == 11) begin
                    if ($urandom_range(0, 3) == 0) begin
                        len = $urandom_range(N_BANDS - 4, N_BANDS + 4);
                    end else begin
                        len = $urandom_range(1, 4);
                    end
                    send_vector(OP_PIXEL, len, FILL_RANDOM);
                end else if (kind <= 13) begin
                    len = $urandom_range(1, 8);
                    send_vector(OP_PIXEL, len, FILL_COPY);
                end else if (kind == 14) begin
                    len = $urandom_range(1, 6);
                    send_vector(OP_PIXEL, len, FILL_ZERO);
                end else if (kind <= 16) begin
                    len = $urandom_range(1, 12);
                    send_vector(OP_TARGET, len,
                                ($urandom_range(0, 5) == 0) ? FILL_ZERO : FILL_RANDOM);
                end else begin
                    // broken sequences: random op and random vector ends
                    len = $urandom_range(1, 10);
                    for (int k = 0; k < len; k++) begin
                        send_req(1'($urandom_range(0, 1)), samp_pick(),
                                 $urandom_range(0, 2) == 0);
                    end
                end
                sent += len;
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d band requests, %0d pixel results, %0d threshold settings",
                 sb.requests_seen, sb.results_checked, thr_writes);
        $display("with %0d saturating accumulations and over-long vectors.", sb.saturations);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("spectral_angle_similarity_top test passed");
        end else begin
            $display("spectral_angle_similarity_top test failed");
        end
        $finish;
    end

endmodule
